>>> hw/rtl/bilinear_lut_interpolator_assert.svh
// assertion macros shared by the interpolator rtl
`ifndef BILINEAR_LUT_INTERPOLATOR_ASSERT_SVH
`define BILINEAR_LUT_INTERPOLATOR_ASSERT_SVH

// clocked check, quiet while reset is high
`define BLI_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) expr) else $error("%m: check failed");

// clocked check that also covers the reset cycles
`define BLI_ASSERT_RST(label, expr) \
  label: assert property (@(posedge clk) expr) else $error("%m: reset check failed");

`endif

>>> hw/rtl/bli_pkg.sv
// ----------------------------------------------------------------------------
// bli_pkg
// types, codes and constants of the bilinear lookup-table interpolator
// ----------------------------------------------------------------------------
`default_nettype none

package bli_pkg;

  localparam int DEF_MAX_AOD = 16;
  localparam int DEF_MAX_H2O = 16;
  localparam int DEF_MAX_WL  = 64;

  localparam int CNT_W  = 7;   // counts up to 64
  localparam int CFG_W  = 7;   // widest register
  localparam int VAL_W  = 16;
  localparam int WGT_W  = 17;  // q1.16 weight in [0, 1.0]
  localparam int CW_W   = 33;  // corner weight in [0, 2^32]
  localparam int ACC_W  = 49;
  localparam int FRAC_W = 16;

  localparam logic [1:0] CMD_AOD   = 2'd0;
  localparam logic [1:0] CMD_H2O   = 2'd1;
  localparam logic [1:0] CMD_TABLE = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  localparam logic [1:0] REG_AOD_COUNT = 2'd0;
  localparam logic [1:0] REG_H2O_COUNT = 2'd1;
  localparam logic [1:0] REG_WL_COUNT  = 2'd2;

  localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(65536);

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  aod_index;
    logic [3:0]  h2o_index;
    logic [5:0]  wl_index;
    logic [15:0] aod_value;
    logic [15:0] h2o_value;
    logic [15:0] r_atm_in;
    logic [15:0] t_down_in;
    logic [15:0] t_up_in;
    logic [15:0] s_alb_in;
  } in_word_t;

  typedef struct packed {
    logic [5:0]  wl_out;
    logic [15:0] r_atm_out;
    logic [15:0] t_down_out;
    logic [15:0] t_up_out;
    logic [15:0] s_alb_out;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic        start;
    logic [15:0] num;
    logic [15:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [15:0] quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SCMP,
    ST_LD0,
    ST_LD1,
    ST_WGT,
    ST_DIV,
    ST_CW,
    ST_MAC
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/bli_if.sv
// ----------------------------------------------------------------------------
// bli_in_if / bli_out_if
// valid/ready channels for command words and result words
// ----------------------------------------------------------------------------
`default_nettype none

interface bli_in_if import bli_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bli_out_if import bli_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bli_div.sv
// ----------------------------------------------------------------------------
// bli_div
// radix-2 restoring divider, one quotient bit a cycle, num < den
// ----------------------------------------------------------------------------
`default_nettype none

module bli_div import bli_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int IW = $clog2(FRAC_W);

  logic          busy;
  logic          done;
  logic [IW-1:0] iter;
  logic [15:0]   rem;
  logic [15:0]   den;
  logic [15:0]   quo;
  logic [16:0]   sh;
  logic          fits;

  // remainder stays below den, so the doubled value fits 17 bits
  assign sh   = {rem, 1'b0};
  assign fits = sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        iter <= '0;
        rem  <= req.num;
        den  <= req.den;
        quo  <= '0;
      end else if (busy) begin
        rem  <= fits ? 16'(sh - {1'b0, den}) : sh[15:0];
        quo  <= {quo[14:0], fits};
        iter <= iter + 1'b1;
        if (iter == IW'(FRAC_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

`default_nettype wire

>>> hw/rtl/bilinear_lut_interpolator.sv
// ----------------------------------------------------------------------------
// bilinear_lut_interpolator
// two-axis grid search, weight division and bilinear interpolation of four
// quantities per wavelength out of a node and table store
// ----------------------------------------------------------------------------
// channel   dir   handshake     word
// item      in    valid/ready   command: node write, table write or query
// result    out   valid/ready   one interpolated wavelength, last on the end
// cfg       in    cfg_we        node counts and wavelength count, no wait
//
// ready is high only while the sequencer is idle
// a query runs a bracket search per axis, loads the bracket nodes and sets the
//   weight, through the shared divider when the weight is a true fraction, then
//   forms the corner weights on the shared multiplier and sums each wavelength
//   (one store read port, four corners read one after another)
// a stalled result word holds the sequencer at the end of the wavelength
// reset (rst, synchronous) restores the counts; node and table contents are
//   undefined until written
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_lut_interpolator import bli_pkg::*; #(
  parameter int MAX_AOD = DEF_MAX_AOD,
  parameter int MAX_H2O = DEF_MAX_H2O,
  parameter int MAX_WL  = DEF_MAX_WL
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  bli_in_if.sink          item,
  bli_out_if.source       result
);

  localparam int AIW   = (MAX_AOD > 1) ? $clog2(MAX_AOD) : 1;
  localparam int HIW   = (MAX_H2O > 1) ? $clog2(MAX_H2O) : 1;
  localparam int WLW   = (MAX_WL > 1) ? $clog2(MAX_WL) : 1;
  localparam int SIW   = (AIW > HIW) ? AIW : HIW;
  localparam int DEPTH = MAX_AOD * MAX_H2O * MAX_WL;
  localparam int SAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration registers, saturated into [1, MAX]
  logic [CNT_W-1:0] aod_count;
  logic [CNT_W-1:0] h2o_count;
  logic [CNT_W-1:0] wl_count;

  function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] v,
                                               input int mx);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    else if (32'(v) > mx) r = CNT_W'(mx);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      aod_count <= sat_cnt(CNT_W'(16), MAX_AOD);
      h2o_count <= sat_cnt(CNT_W'(16), MAX_H2O);
      wl_count  <= sat_cnt(CNT_W'(64), MAX_WL);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AOD_COUNT: aod_count <= sat_cnt({2'b00, cfg_data[4:0]}, MAX_AOD);
        REG_H2O_COUNT: h2o_count <= sat_cnt({2'b00, cfg_data[4:0]}, MAX_H2O);
        REG_WL_COUNT:  wl_count  <= sat_cnt(cfg_data, MAX_WL);
        default: ;
      endcase
    end
  end

  // sequencer and query registers
  state_t           state;
  state_t           state_next;
  logic             axis;         // 0 aod, 1 h2o
  logic [SIW-1:0]   si;           // lower bracket node
  logic [SIW-1:0]   i1r;          // upper bracket node
  logic [15:0]      av;
  logic [15:0]      hv;
  logic [15:0]      n0;
  logic [15:0]      n1;
  logic [SIW-1:0]   a0, a1, h0, h1;
  logic [WGT_W-1:0] wa, wh;
  logic [1:0]       k;            // corner weight counter
  logic [CW_W-1:0]  cw [4];
  logic [WLW-1:0]   wl;
  logic [2:0]       step;         // wavelength step: reads 0..3, emit at 6

  logic             in_acc;
  logic             is_query;
  logic             ovalid;
  out_word_t        odata;
  logic             out_free;

  assign in_acc   = item.valid && item.ready;
  assign is_query = in_acc && item.data.cmd == CMD_QUERY;
  assign out_free = !ovalid || result.ready;

  // node memories, one registered read port each
  logic [15:0]    aod_mem [MAX_AOD];
  logic [15:0]    h2o_mem [MAX_H2O];
  logic [15:0]    aod_rd;
  logic [15:0]    h2o_rd;
  logic [SIW-1:0] node_addr;
  logic [15:0]    node_rd;

  always_ff @(posedge clk) begin
    if (in_acc && item.data.cmd == CMD_AOD && 32'(item.data.aod_index) < MAX_AOD)
      aod_mem[AIW'(item.data.aod_index)] <= item.data.aod_value;
    if (in_acc && item.data.cmd == CMD_H2O && 32'(item.data.h2o_index) < MAX_H2O)
      h2o_mem[HIW'(item.data.h2o_index)] <= item.data.h2o_value;
    aod_rd <= aod_mem[AIW'(node_addr)];
    h2o_rd <= h2o_mem[HIW'(node_addr)];
  end

  // table store, 64-bit word of four q1.15 lanes
  logic [63:0]    store_mem [DEPTH];
  logic [63:0]    store_rd;
  logic [SAW-1:0] wr_addr;
  logic [SAW-1:0] rd_addr;
  logic           tbl_we;
  logic [1:0]     corner;
  logic [SIW-1:0] ca;
  logic [SIW-1:0] ch;

  assign tbl_we = in_acc && item.data.cmd == CMD_TABLE &&
                  32'(item.data.aod_index) < MAX_AOD &&
                  32'(item.data.h2o_index) < MAX_H2O &&
                  32'(item.data.wl_index) < MAX_WL;
  assign wr_addr = SAW'((32'(item.data.aod_index) * MAX_H2O +
                         32'(item.data.h2o_index)) * MAX_WL +
                        32'(item.data.wl_index));
  assign corner  = step[1:0];
  assign ca      = corner[0] ? a1 : a0;
  assign ch      = corner[1] ? h1 : h0;
  assign rd_addr = SAW'((32'(ca) * MAX_H2O + 32'(ch)) * MAX_WL + 32'(wl));

  always_ff @(posedge clk) begin
    if (tbl_we)
      store_mem[wr_addr] <= {item.data.s_alb_in, item.data.t_up_in,
                             item.data.t_down_in, item.data.r_atm_in};
    store_rd <= store_mem[rd_addr];
  end

  // axis selection
  logic [CNT_W-1:0] cur_cnt;
  logic [15:0]      cur_v;
  logic             srch_more;
  logic [SIW-1:0]   i1_calc;

  assign cur_cnt   = axis ? h2o_count : aod_count;
  assign cur_v     = axis ? hv : av;
  assign node_rd   = axis ? h2o_rd : aod_rd;
  assign srch_more = (32'(si) + 32'd2) < 32'(cur_cnt);
  assign i1_calc   = ((32'(si) + 32'd1) < 32'(cur_cnt)) ? SIW'(si + 1'b1) : si;

  // weight decision on the bracket pair
  logic [16:0] d;
  logic [16:0] e;
  logic [15:0] ad;
  logic [15:0] ae;
  logic        w_zero;
  logic        w_full;
  logic        need_div;

  assign d        = {1'b0, cur_v} - {1'b0, n0};
  assign e        = {1'b0, n1} - {1'b0, n0};
  assign ad       = d[16] ? 16'(-d) : d[15:0];
  assign ae       = e[16] ? 16'(-e) : e[15:0];
  assign w_zero   = (i1r == si) || (e == '0) || (d == '0) || (d[16] != e[16]);
  assign w_full   = ad >= ae;
  assign need_div = !w_zero && !w_full;

  div_req_t dreq;
  div_rsp_t drsp;

  bli_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  assign dreq.start = (state == ST_WGT) && need_div;
  assign dreq.num   = ad;
  assign dreq.den   = ae;

  // next state
  logic wl_last;
  assign wl_last = (32'(wl) + 32'd1) == 32'(wl_count);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (is_query) state_next = ST_SRCH;
      ST_SRCH: state_next = srch_more ? ST_SCMP : ST_LD0;
      ST_SCMP: state_next = (node_rd <= cur_v) ? ST_SRCH : ST_LD0;
      ST_LD0:  state_next = ST_LD1;
      ST_LD1:  state_next = ST_WGT;
      ST_WGT: begin
        if (need_div) state_next = ST_DIV;
        else state_next = axis ? ST_CW : ST_SRCH;
      end
      ST_DIV:  if (drsp.done) state_next = axis ? ST_CW : ST_SRCH;
      ST_CW:   if (k == 2'd3) state_next = ST_MAC;
      ST_MAC:  if (step == 3'd6 && out_free && wl_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    item.ready = 1'b0;
    node_addr  = si;
    unique case (state)
      ST_IDLE: item.ready = 1'b1;
      ST_SRCH: node_addr = srch_more ? SIW'(si + 1'b1) : si;
      ST_LD0:  node_addr = i1_calc;
      default: ;
    endcase
  end

  // weight commit at the end of each axis
  logic             w_commit;
  logic [WGT_W-1:0] w_val;

  always_comb begin
    w_commit = 1'b0;
    w_val    = '0;
    if (state == ST_WGT && !need_div) begin
      w_commit = 1'b1;
      w_val    = w_zero ? '0 : WGT_ONE;
    end else if (state == ST_DIV && drsp.done) begin
      w_commit = 1'b1;
      w_val    = {1'b0, drsp.quo};
    end
  end

  // shared weight multiplier
  logic [WGT_W-1:0] fa;
  logic [WGT_W-1:0] fh;
  assign fa = k[0] ? wa : WGT_W'(WGT_ONE - wa);
  assign fh = k[1] ? wh : WGT_W'(WGT_ONE - wh);

  // lane multiply pipeline
  logic            rv1;
  logic [1:0]      c1;
  logic            pv;
  logic [ACC_W-1:0] prod [4];
  logic [ACC_W-1:0] acc  [4];
  logic [15:0]      lane_res [4];

  always_comb begin
    logic [ACC_W:0] rsum;
    for (int i = 0; i < 4; i++) begin
      rsum = {1'b0, acc[i]} + (ACC_W+1)'(33'h0_8000_0000);
      lane_res[i] = (rsum[ACC_W:32] > 17'd65535) ? 16'hFFFF : rsum[47:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      axis   <= 1'b0;
      ovalid <= 1'b0;
      rv1    <= 1'b0;
      pv     <= 1'b0;
      wa     <= '0;
      wh     <= '0;
    end else begin
      state <= state_next;
      rv1   <= state == ST_MAC && !step[2];
      pv    <= rv1;
      if (ovalid && result.ready) ovalid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (is_query) begin
            av   <= item.data.aod_value;
            hv   <= item.data.h2o_value;
            axis <= 1'b0;
            si   <= '0;
          end
        end
        ST_SCMP: if (node_rd <= cur_v) si <= SIW'(si + 1'b1);
        ST_LD0: begin
          n0  <= node_rd;
          i1r <= i1_calc;
        end
        ST_LD1: n1 <= node_rd;
        ST_CW: begin
          cw[k] <= CW_W'(fa * fh);
          k     <= k + 1'b1;
          wl    <= '0;
          step  <= '0;
        end
        ST_MAC: begin
          if (step != 3'd6) begin
            step <= step + 1'b1;
          end else if (out_free) begin
            ovalid           <= 1'b1;
            odata.wl_out     <= 6'(wl);
            odata.r_atm_out  <= lane_res[0];
            odata.t_down_out <= lane_res[1];
            odata.t_up_out   <= lane_res[2];
            odata.s_alb_out  <= lane_res[3];
            odata.last       <= wl_last;
            wl               <= WLW'(wl + 1'b1);
            step             <= '0;
          end
        end
        default: ;
      endcase

      if (w_commit) begin
        if (!axis) begin
          a0   <= si;
          a1   <= i1r;
          wa   <= w_val;
          axis <= 1'b1;
          si   <= '0;
        end else begin
          h0 <= si;
          h1 <= i1r;
          wh <= w_val;
          k  <= '0;
        end
      end
    end
  end

  // lane products and accumulation, no reset needed on payload
  always_ff @(posedge clk) begin
    c1 <= corner;
    for (int i = 0; i < 4; i++) begin
      prod[i] <= ACC_W'({33'b0, store_rd[16*i +: 16]} * {16'b0, cw[c1]});
      if (state == ST_MAC && step == 3'd0) acc[i] <= '0;
      else if (pv) acc[i] <= acc[i] + prod[i];
    end
  end

  assign result.valid = ovalid;
  assign result.data  = odata;

  `include "bilinear_lut_interpolator_assert.svh"

  `BLI_ASSERT_RST(a_reset_idle, rst |=> (state == ST_IDLE && !ovalid))
  `BLI_ASSERT(a_query_starts, is_query |=> state == ST_SRCH)
  `BLI_ASSERT(a_word_from_mac, $rose(result.valid) |-> $past(state) == ST_MAC)
  `BLI_ASSERT(a_div_done_in_div, drsp.done |-> state == ST_DIV)
  `BLI_ASSERT(a_weights_in_range, (wa <= WGT_ONE) && (wh <= WGT_ONE))

endmodule

`default_nettype wire

>>> bench/bilinear_lut_interpolator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bilinear_lut_interpolator_tb
// self-checking bench: loads grid axes and the table, runs queries over
// several count settings and compares every result word with a bit-exact
// predictor of the bracket search, weight division and interpolation
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_lut_interpolator_tb;
  import bli_pkg::*;

  localparam int LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_AOD_COUNT;
  logic [CFG_W-1:0] cfg_data = '0;

  bli_in_if  item ();
  bli_out_if result ();

  bilinear_lut_interpolator dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .item(item.sink), .result(result.source)
  );

  always #5 clk = ~clk;

  // predictor copy of the block's state
  logic [15:0] aod_grid [16];
  logic [15:0] h2o_grid [16];
  logic [63:0] lut [16384];
  int aod_used = 16, h2o_used = 16, wl_used = 64;

  out_word_t pending_words [$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;       // no idling on either side while set
  int hold_cycles = 0;    // long receiver hold-off

  initial begin
    item.valid = 1'b0;
    item.data = '0;
    result.ready = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // bracket pair and q1.16 weight on one axis
  function automatic void find_bracket(input logic [15:0] nodes [16], input int n,
                                       input int v, output int lo, output int hi,
                                       output longint wt);
    int d, e;
    lo = 0;
    while (lo < n - 2 && int'(nodes[lo + 1]) <= v) lo++;
    hi = (lo < n - 1) ? lo + 1 : lo;
    wt = 0;
    if (hi != lo) begin
      d = v - int'(nodes[lo]);
      e = int'(nodes[hi]) - int'(nodes[lo]);
      // equal nodes, exact hit or coordinate on the wrong side: weight 0
      if (e != 0 && d != 0 && ((d > 0) == (e > 0))) begin
        if (d < 0) d = -d;
        if (e < 0) e = -e;
        if (d >= e) wt = 65536;
        else wt = (longint'(d) << 16) / e;
      end
    end
  endfunction

  function automatic int lut_addr(int a, int h, int w);
    return (a * 16 + h) * 64 + w;
  endfunction

  // apply one accepted command word to the predictor, queue any results
  task automatic predict_word(input in_word_t w);
    int a0, a1, h0, h1;
    longint wa, wh;
    longint unsigned cw [4];
    logic [63:0] c [4];
    longint unsigned s, r;
    logic [15:0] lanes [4];
    out_word_t o;
    case (w.cmd)
      CMD_AOD:   aod_grid[w.aod_index] = w.aod_value;
      CMD_H2O:   h2o_grid[w.h2o_index] = w.h2o_value;
      CMD_TABLE: lut[lut_addr(w.aod_index, w.h2o_index, w.wl_index)] =
                   {w.s_alb_in, w.t_up_in, w.t_down_in, w.r_atm_in};
      default: begin
        find_bracket(aod_grid, aod_used, w.aod_value, a0, a1, wa);
        find_bracket(h2o_grid, h2o_used, w.h2o_value, h0, h1, wh);
        cw[0] = (65536 - wa) * (65536 - wh);
        cw[1] = wa * (65536 - wh);
        cw[2] = (65536 - wa) * wh;
        cw[3] = wa * wh;
        for (int k = 0; k < wl_used; k++) begin
          c[0] = lut[lut_addr(a0, h0, k)];
          c[1] = lut[lut_addr(a1, h0, k)];
          c[2] = lut[lut_addr(a0, h1, k)];
          c[3] = lut[lut_addr(a1, h1, k)];
          for (int q = 0; q < 4; q++) begin
            s = 0;
            for (int j = 0; j < 4; j++) s += longint'(c[j][16*q +: 16]) * cw[j];
            r = (s + 64'h8000_0000) >> 32;
            lanes[q] = (r > 65535) ? 16'hFFFF : r[15:0];
          end
          o.wl_out = k[5:0];
          o.r_atm_out = lanes[0];
          o.t_down_out = lanes[1];
          o.t_up_out = lanes[2];
          o.s_alb_out = lanes[3];
          o.last = (k + 1 == wl_used);
          pending_words.push_back(o);
        end
      end
    endcase
  endtask

  function automatic int clip_count(int v, int top);
    return (v < 1) ? 1 : (v > top) ? top : v;
  endfunction

  // ---------------------------------------------------------------- drivers

  // offer one word, with random gaps in front unless quiet is set, until it is taken
  task automatic send_word(input in_word_t w);
    if (!quiet)
      while ($urandom_range(0, 99) < 16) begin
        item.valid <= 1'b0;
        @(posedge clk);
      end
    item.valid <= 1'b1;
    item.data <= w;
    do @(posedge clk); while (!item.ready);
    predict_word(w);
  endtask

  function automatic in_word_t make_word(logic [1:0] cmd);
    in_word_t w;
    w = in_word_t'({$urandom, $urandom, $urandom, $urandom});
    w.cmd = cmd;
    return w;
  endfunction

  task automatic node_write(logic [1:0] cmd, int idx, int v);
    in_word_t w;
    w = make_word(cmd);
    w.aod_index = idx[3:0];
    w.h2o_index = idx[3:0];
    w.aod_value = v[15:0];
    w.h2o_value = v[15:0];
    send_word(w);
  endtask

  task automatic query(int av, int hv);
    in_word_t w;
    w = make_word(CMD_QUERY);
    w.aod_value = av[15:0];
    w.h2o_value = hv[15:0];
    send_word(w);
  endtask

  // block drained: every result in and the sequencer back to idle
  task automatic wait_idle();
    item.valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int v);
    item.valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_AOD_COUNT: aod_used = clip_count(v & 31, 16);
      REG_H2O_COUNT: h2o_used = clip_count(v & 31, 16);
      REG_WL_COUNT:  wl_used = clip_count(v & 127, 64);
      default: ;
    endcase
  endtask

  task automatic set_counts(int a, int h, int wl);
    write_reg(REG_AOD_COUNT, a);
    write_reg(REG_H2O_COUNT, h);
    write_reg(REG_WL_COUNT, wl);
  endtask

  // ---------------------------------------------------------------- receiver

  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      result.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      result.ready <= quiet || ($urandom_range(0, 99) >= 16);
    end
  end

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  // compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && result.valid && result.ready) begin
      if (pending_words.size() == 0) begin
        report("unexpected word wl", result.data.wl_out, -1);
      end else begin
        want = pending_words.pop_front();
        if (result.data.wl_out !== want.wl_out)
          report("wl_out", result.data.wl_out, want.wl_out);
        if (result.data.r_atm_out !== want.r_atm_out)
          report("r_atm_out", result.data.r_atm_out, want.r_atm_out);
        if (result.data.t_down_out !== want.t_down_out)
          report("t_down_out", result.data.t_down_out, want.t_down_out);
        if (result.data.t_up_out !== want.t_up_out)
          report("t_up_out", result.data.t_up_out, want.t_up_out);
        if (result.data.s_alb_out !== want.s_alb_out)
          report("s_alb_out", result.data.s_alb_out, want.s_alb_out);
        if (result.data.last !== want.last)
          report("last", result.data.last, want.last);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL bilinear_lut_interpolator");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  // ascending grids with random spacing, then every table entry written so
  // that no query ever reads an unwritten location
  task automatic test_load_store();
    in_word_t w;
    quiet = 1'b1;
    for (int i = 0; i < 16; i++) begin
      node_write(CMD_AOD, i, i * 4096 + $urandom_range(0, 2047));
      node_write(CMD_H2O, i, i * 4096 + $urandom_range(0, 2047));
    end
    for (int a = 0; a < 16; a++)
      for (int h = 0; h < 16; h++)
        for (int k = 0; k < 64; k++) begin
          w = make_word(CMD_TABLE);
          w.aod_index = a[3:0];
          w.h2o_index = h[3:0];
          w.wl_index = k[5:0];
          send_word(w);
        end
    quiet = 1'b0;
  endtask

  // grid extremes, exact node hits, equal neighbours, saturated table words
  task automatic test_directed();
    in_word_t w;
    set_counts(16, 16, 4);
    query(0, 0);
    query(16'hFFFF, 16'hFFFF);
    query(aod_grid[5], h2o_grid[9]);
    query(aod_grid[14] + 1, h2o_grid[0] + 1);
    // full-scale corners around the first cell
    for (int j = 0; j < 4; j++) begin
      w = make_word(CMD_TABLE);
      w.aod_index = {3'b000, j[0]};
      w.h2o_index = {3'b000, j[1]};
      w.wl_index = '0;
      {w.r_atm_in, w.t_down_in, w.t_up_in, w.s_alb_in} = '1;
      send_word(w);
    end
    query(aod_grid[0] + 100, h2o_grid[0] + 100);
    // equal neighbouring nodes
    node_write(CMD_AOD, 3, aod_grid[2]);
    node_write(CMD_H2O, 7, h2o_grid[6]);
    query(aod_grid[2], h2o_grid[6] + 5);
    query(aod_grid[2] + 9, h2o_grid[6]);
    wait_idle();
    // single node on each axis, counts given as zero, register beyond list
    set_counts(0, 0, 1);
    write_reg(2'd3, 5);
    query($urandom, $urandom);
    query(0, 16'hFFFF);
    wait_idle();
    set_counts(2, 31, 127);
    query(aod_grid[1] + 50, h2o_grid[15] - 1);
    wait_idle();
  endtask

  // sweep of count settings with a few queries each
  task automatic test_count_sweep();
    int sets [6][3] = '{'{1, 16, 2}, '{16, 1, 3}, '{2, 2, 64}, '{16, 16, 1},
                        '{9, 5, 7}, '{17, 20, 100}};
    for (int s = 0; s < 6; s++) begin
      set_counts(sets[s][0], sets[s][1], sets[s][2]);
      repeat (3) query($urandom_range(0, 65535), $urandom_range(0, 65535));
      wait_idle();
    end
  endtask

  // mostly tidy grid updates and queries inside the grid, some raw noise
  task automatic test_random(int total);
    int done = 0;
    int pick, i;
    in_word_t w;
    while (done < total) begin
      set_counts($urandom_range(1, 16), $urandom_range(1, 16),
                 ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 8));
      quiet = ($urandom_range(0, 5) == 0);
      repeat (40) begin
        pick = $urandom_range(0, 99);
        i = $urandom_range(0, 15);
        if (pick < 12) begin
          node_write(CMD_AOD, i, (pick < 10) ? i * 4096 + $urandom_range(0, 4095)
                                             : $urandom_range(0, 65535));
        end else if (pick < 24) begin
          node_write(CMD_H2O, i, (pick < 22) ? i * 4096 + $urandom_range(0, 4095)
                                             : $urandom_range(0, 65535));
        end else if (pick < 60) begin
          send_word(make_word(CMD_TABLE));
        end else if (pick < 90) begin
          query(aod_grid[$urandom_range(0, aod_used - 1)] + $urandom_range(0, 4096),
                h2o_grid[$urandom_range(0, h2o_used - 1)] + $urandom_range(0, 4096));
        end else begin
          w = make_word(CMD_QUERY);
          send_word(w);
        end
        done++;
      end
      wait_idle();
    end
    quiet = 1'b0;
  endtask

  // receiver holds off while queries keep coming, so the block stalls
  task automatic test_backpressure();
    set_counts(16, 16, 6);
    @(posedge clk);
    hold_cycles <= 400;
    repeat (6) query($urandom_range(0, 65535), $urandom_range(0, 65535));
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_load_store();
    test_directed();
    test_count_sweep();
    test_backpressure();
    test_random(460);
    wait_idle();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("PASS bilinear_lut_interpolator");
    end else begin
      $display("FAIL bilinear_lut_interpolator");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
+incdir+hw/rtl
hw/rtl/bli_pkg.sv
hw/rtl/bli_if.sv
hw/rtl/bli_div.sv
hw/rtl/bilinear_lut_interpolator.sv
bench/bilinear_lut_interpolator_tb.sv
